// ----- rtl/rtw_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the recursive twiddle multiplier.
// Used by rtw_cmul and by recursive_twiddle_multiplier_unit; depends on nothing.
package rtw_pkg;

	localparam int RTW_POINTS   = 256;
	localparam int RTW_ADDR_W   = $clog2(RTW_POINTS);
	localparam int RTW_SAMPLE_W = 16;
	localparam int RTW_OUT_W    = 16;
	localparam int RTW_IDX_W    = 8;
	localparam int RTW_KIND_W   = 2;
	localparam int RTW_WORD_W   = 18;
	localparam int RTW_FRAC_W   = 16;
	localparam int RTW_PROD_W   = 2 * RTW_WORD_W;
	localparam int RTW_SUM_W    = RTW_PROD_W + 1;
	localparam int RTW_RND_W    = RTW_SUM_W - RTW_FRAC_W;

	localparam int RTW_IN_DATA_W  = ((RTW_IDX_W + 2 * RTW_WORD_W + 7) / 8) * 8;
	localparam int RTW_OUT_DATA_W = ((2 * RTW_OUT_W + 7) / 8) * 8;

	localparam logic [RTW_KIND_W-1:0] RTW_KIND_TWIDDLE = 2'd0;
	localparam logic [RTW_KIND_W-1:0] RTW_KIND_STEP    = 2'd1;
	localparam logic [RTW_KIND_W-1:0] RTW_KIND_SAMPLE  = 2'd2;

	localparam logic [RTW_ADDR_W-1:0] RTW_LAST_POS = RTW_ADDR_W'(RTW_POINTS - 1);

	typedef struct packed {
		logic signed [RTW_WORD_W-1:0] im;
		logic signed [RTW_WORD_W-1:0] re;
	} rtw_cplx_t;

	typedef struct packed {
		logic signed [RTW_RND_W-1:0] im;
		logic signed [RTW_RND_W-1:0] re;
	} rtw_rnd_t;

endpackage

// ----- rtl/recursive_twiddle_multiplier_unit.sv -----
`timescale 1ns / 1ps
// Top level of the recursive twiddle multiplier: twiddle and step tables, position
// counter, two-stage datapath and output register. Depends on rtw_pkg and rtw_cmul.
//
//  channel   direction  contents
//  s_axis    in         tuser = kind; tdata = load_index, value_re, value_im
//  m_axis    out        tdata = out_re, out_im; tlast = frame_last
//
// One item is accepted per cycle unless stalled; a sample moves through the
// first and second stages into the output register. A sample whose table entry
// is still being written by the item ahead of it (typically the first sample after
// a load of that entry) waits in the first stage until that write is made. Reset
// clears the position and all valid flags; the tables are not cleared and hold
// nothing until loaded. A stalled output holds its result as earlier stages fill.
module recursive_twiddle_multiplier_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// kind
	input  logic [rtw_pkg::RTW_KIND_W-1:0]      s_axis_tuser,
	// load_index [7:0], value_re [25:8], value_im [43:26], zero fill above
	input  logic [rtw_pkg::RTW_IN_DATA_W-1:0]   s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_re [15:0], out_im [31:16]
	output logic [rtw_pkg::RTW_OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                                m_axis_tlast
);

	localparam int W  = rtw_pkg::RTW_WORD_W;
	localparam int AW = rtw_pkg::RTW_ADDR_W;
	localparam longint SAMPLE_MAX = (longint'(1) << (rtw_pkg::RTW_SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam longint WORD_MAX   = (longint'(1) << (W - 1)) - 1;
	localparam longint WORD_MIN   = -WORD_MAX - 1;

	function automatic logic [rtw_pkg::RTW_OUT_W-1:0] sat_sample(
		input logic signed [rtw_pkg::RTW_RND_W-1:0] x);
		longint v;
		v = longint'(x);
		if (v > SAMPLE_MAX) v = SAMPLE_MAX;
		if (v < SAMPLE_MIN) v = SAMPLE_MIN;
		return rtw_pkg::RTW_OUT_W'(v);
	endfunction

	function automatic logic signed [W-1:0] sat_word(
		input logic signed [rtw_pkg::RTW_RND_W-1:0] x);
		longint v;
		v = longint'(x);
		if (v > WORD_MAX) v = WORD_MAX;
		if (v < WORD_MIN) v = WORD_MIN;
		return W'(v);
	endfunction

	// Input decode.
	logic [rtw_pkg::RTW_IDX_W-1:0] in_idx;
	rtw_pkg::rtw_cplx_t            in_value;
	logic                          in_sample, in_load, in_tw_we, in_st_we, in_range;
	logic                          accept, s1_load;

	// Pipeline control.
	logic          s1_v_q, s2_v_q, out_v_q;
	logic          out_rdy, s2_go, s2_free, s1_go, s1_free, haz;
	logic [AW-1:0] pos_q;

	// Stage payloads.
	logic               sample_s1, tw_we_s1, st_we_s1, last_s1;
	logic [AW-1:0]      addr_s1;
	rtw_pkg::rtw_cplx_t value_s1, tw_rd_s1, st_rd_s1, tw_fwd_s1, st_fwd_s1;
	logic               tw_fwd_v_q, st_fwd_v_q;
	rtw_pkg::rtw_cplx_t tw_eff, st_eff;
	logic               sample_s2, tw_we_s2, st_we_s2, last_s2;
	logic [AW-1:0]      addr_s2;
	rtw_pkg::rtw_cplx_t value_s2;
	rtw_pkg::rtw_rnd_t  rnd_out, rnd_upd;

	// Table write port.
	logic               tw_we, st_we;
	rtw_pkg::rtw_cplx_t tw_wdata;

	logic [rtw_pkg::RTW_OUT_W-1:0] out_re_q, out_im_q;
	logic                          out_last_q;

	rtw_pkg::rtw_cplx_t twd_mem [rtw_pkg::RTW_POINTS];
	rtw_pkg::rtw_cplx_t stp_mem [rtw_pkg::RTW_POINTS];

	always_comb begin
		in_idx      = s_axis_tdata[rtw_pkg::RTW_IDX_W-1:0];
		in_value.re = s_axis_tdata[rtw_pkg::RTW_IDX_W +: W];
		in_value.im = s_axis_tdata[rtw_pkg::RTW_IDX_W + W +: W];
		in_range    = 32'(in_idx) < 32'(rtw_pkg::RTW_POINTS);
		in_sample   = 1'b0;
		in_load     = 1'b0;
		in_tw_we    = 1'b0;
		in_st_we    = 1'b0;
		case (s_axis_tuser)
			rtw_pkg::RTW_KIND_TWIDDLE: begin
				in_load  = 1'b1;
				in_tw_we = in_range;
			end
			rtw_pkg::RTW_KIND_STEP: begin
				in_load  = 1'b1;
				in_st_we = in_range;
			end
			rtw_pkg::RTW_KIND_SAMPLE: begin
				in_sample = 1'b1;
				in_tw_we  = 1'b1;
			end
			default: begin
				in_load = 1'b0;
			end
		endcase
	end

	always_comb begin
		out_rdy       = !out_v_q || m_axis_tready;
		s2_go         = s2_v_q && (!sample_s2 || out_rdy);
		s2_free       = !s2_v_q || s2_go;
		haz           = s1_v_q && sample_s1 && s2_v_q && (tw_we_s2 || st_we_s2) &&
		                (addr_s2 == addr_s1);
		s1_go         = s1_v_q && s2_free && !haz;
		s1_free       = !s1_v_q || s1_go;
		s_axis_tready = s1_free;
		accept        = s_axis_tvalid && s_axis_tready;
		s1_load       = accept && (in_sample || in_load);
		tw_we         = s2_go && tw_we_s2;
		st_we         = s2_go && st_we_s2;
		tw_wdata      = value_s2;
		if (sample_s2) begin
			tw_wdata.re = sat_word(rnd_upd.re);
			tw_wdata.im = sat_word(rnd_upd.im);
		end
		tw_eff = tw_fwd_v_q ? tw_fwd_s1 : tw_rd_s1;
		st_eff = st_fwd_v_q ? st_fwd_s1 : st_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			s1_v_q     <= 1'b0;
			s2_v_q     <= 1'b0;
			out_v_q    <= 1'b0;
			tw_fwd_v_q <= 1'b0;
			st_fwd_v_q <= 1'b0;
		end else begin
			if (accept && in_load) begin
				pos_q <= '0;
			end else if (accept && in_sample) begin
				pos_q <= (pos_q == rtw_pkg::RTW_LAST_POS) ? '0 : pos_q + AW'(1);
			end
			if (s1_free) begin
				s1_v_q <= s1_load;
			end
			if (s2_free) begin
				s2_v_q <= s1_go;
			end
			if (s2_go && sample_s2) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (s1_load) begin
				tw_fwd_v_q <= tw_we && (addr_s2 == pos_q);
				st_fwd_v_q <= st_we && (addr_s2 == pos_q);
			end else begin
				if (tw_we && (addr_s2 == addr_s1)) begin
					tw_fwd_v_q <= 1'b1;
				end
				if (st_we && (addr_s2 == addr_s1)) begin
					st_fwd_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tw_we) begin
			twd_mem[addr_s2] <= tw_wdata;
		end
		if (st_we) begin
			stp_mem[addr_s2] <= value_s2;
		end
		if (s1_load) begin
			tw_rd_s1 <= twd_mem[pos_q];
			st_rd_s1 <= stp_mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			sample_s1 <= in_sample;
			tw_we_s1  <= in_tw_we;
			st_we_s1  <= in_st_we;
			last_s1   <= in_sample && (pos_q == rtw_pkg::RTW_LAST_POS);
			addr_s1   <= in_sample ? pos_q : AW'(in_idx);
			value_s1  <= in_value;
			tw_fwd_s1 <= tw_wdata;
			st_fwd_s1 <= value_s2;
		end else begin
			if (tw_we && (addr_s2 == addr_s1)) begin
				tw_fwd_s1 <= tw_wdata;
			end
			if (st_we && (addr_s2 == addr_s1)) begin
				st_fwd_s1 <= value_s2;
			end
		end
		if (s1_go) begin
			sample_s2 <= sample_s1;
			tw_we_s2  <= tw_we_s1;
			st_we_s2  <= st_we_s1;
			last_s2   <= last_s1;
			addr_s2   <= addr_s1;
			value_s2  <= value_s1;
		end
		if (s2_go && sample_s2) begin
			out_re_q   <= sat_sample(rnd_out.re);
			out_im_q   <= sat_sample(rnd_out.im);
			out_last_q <= last_s2;
		end
	end

	rtw_cmul u_cmul_out (
		.clk (clk),
		.en  (s1_go),
		.a   (value_s1),
		.b   (tw_eff),
		.rnd (rnd_out)
	);

	rtw_cmul u_cmul_upd (
		.clk (clk),
		.en  (s1_go),
		.a   (tw_eff),
		.b   (st_eff),
		.rnd (rnd_upd)
	);

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {out_im_q, out_re_q};
	assign m_axis_tlast  = out_last_q;

	a_load_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_load |=> pos_q == '0)
		else $error("Position not cleared after a load item.");

	a_sample_steps_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_sample && (pos_q != rtw_pkg::RTW_LAST_POS)
		|=> pos_q == $past(pos_q) + AW'(1))
		else $error("Position did not advance after a sample item.");

	a_hazard_forwards: assert property (@(posedge clk) disable iff (!arst_n)
		haz && tw_we |=> s1_v_q && tw_fwd_v_q)
		else $error("Twiddle write not forwarded to the waiting sample.");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s2_go && sample_s2 |=> out_v_q)
		else $error("Sample left the datapath without reaching the output register.");

endmodule

// ----- rtl/rtw_cmul.sv -----
`timescale 1ns / 1ps
// Complex multiplier: registered 18x18 partial products, then add, round to nearest.
// Depends on rtw_pkg for the complex operand and result types.
module rtw_cmul (
	input  logic                 clk,
	input  logic                 en,
	input  rtw_pkg::rtw_cplx_t   a,
	input  rtw_pkg::rtw_cplx_t   b,
	output rtw_pkg::rtw_rnd_t    rnd
);

	localparam logic signed [rtw_pkg::RTW_SUM_W-1:0] HALF =
		rtw_pkg::RTW_SUM_W'(1) << (rtw_pkg::RTW_FRAC_W - 1);

	logic signed [rtw_pkg::RTW_PROD_W-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [rtw_pkg::RTW_SUM_W-1:0]  sum_re, sum_im;

	always_ff @(posedge clk) begin
		if (en) begin
			p_rr_s2 <= $signed(a.re) * $signed(b.re);
			p_ii_s2 <= $signed(a.im) * $signed(b.im);
			p_ri_s2 <= $signed(a.re) * $signed(b.im);
			p_ir_s2 <= $signed(a.im) * $signed(b.re);
		end
	end

	always_comb begin
		sum_re = rtw_pkg::RTW_SUM_W'(p_rr_s2) - rtw_pkg::RTW_SUM_W'(p_ii_s2) + HALF;
		sum_im = rtw_pkg::RTW_SUM_W'(p_ri_s2) + rtw_pkg::RTW_SUM_W'(p_ir_s2) + HALF;
		rnd.re = sum_re[rtw_pkg::RTW_SUM_W-1:rtw_pkg::RTW_FRAC_W];
		rnd.im = sum_im[rtw_pkg::RTW_SUM_W-1:rtw_pkg::RTW_FRAC_W];
	end

endmodule
